>>> hw/rtl/iarf_pkg.sv
// Shared types, selector codes and ASCII constants for the integer-to-ASCII formatter.
// Used by iarf_bcd, iarf_emit and integer_to_ascii_radix_formatter; depends on nothing.
package iarf_pkg;

  // Default word size of the converted value
  localparam int WORD_BITS_DEF = 32;

  // Request selector codes (tuser of the input stream)
  localparam logic [2:0] REQ_DEC  = 3'd0;
  localparam logic [2:0] REQ_HEXL = 3'd1;
  localparam logic [2:0] REQ_HEXU = 3'd2;
  localparam logic [2:0] REQ_OCT  = 3'd3;
  localparam logic [2:0] REQ_CHAR = 3'd4;
  localparam logic [2:0] REQ_PCT  = 3'd5;

  // ASCII codes
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_MINUS   = 8'h2d;
  localparam logic [7:0] ASCII_PERCENT = 8'h25;

  // Decimal digits needed for an unsigned word: floor(w * log10(2)) + 1
  function automatic int dec_digits(int w);
    return ((w * 1233) >>> 12) + 1;
  endfunction

  // Load command from the request control to the character emitter.
  // mode uses the request codes; REQ_CHAR means "emit lit_char alone".
  typedef struct packed {
    logic       load;
    logic [2:0] mode;
    logic [7:0] lit_char;
    logic       lit_last;
  } emit_cmd_t;

endpackage

>>> hw/rtl/integer_to_ascii_radix_formatter.sv
// Top level of the integer-to-ASCII formatter: request control, BCD converter, emitter.
// Depends on iarf_pkg, iarf_bcd and iarf_emit.
//
// Usage:
//   Input stream: one transaction per request; tuser carries the selector (signed
//   decimal, lowercase hex, uppercase hex, octal, single character, percent) and
//   tdata the 32-bit value. Selectors 6 and 7 are taken and dropped.
//   Output stream: one transaction per ASCII character, most significant digit
//   first, tlast on the final character of the request.
//   Flow: a hex or octal request occupies the digit shifter for every digit
//   position of the word (8 or 11 at 32 bits), leading zeros included, and no
//   new request is taken until it is through. Signed decimal runs the bit-serial
//   BCD converter over every bit of the word, then the digit shifter over every
//   decimal digit position (10 at 32 bits). Char and percent load a single character.
//   The first character of a hex, octal, char or percent request passes the digit
//   shifter and then the output register; each leading zero dropped delays it.
//   A finished character waits in the output register while the next request is
//   taken; a stalled receiver holds the digit shifter and, once it is busy, tready.
//   Reset clears the controller and drops any character still waiting.
module integer_to_ascii_radix_formatter #(
  parameter int WORD_BITS = iarf_pkg::WORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_char
  output logic        m_axis_tlast_o
);

  localparam int BCD_W = 4 * iarf_pkg::dec_digits(WORD_BITS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CONV = 1'b1;

  logic                 state_q, state_d;
  logic [WORD_BITS-1:0] word, mag;
  logic                 neg, accept;
  logic                 bcd_start, bcd_busy, emit_busy;
  logic [BCD_W-1:0]     bcd;
  iarf_pkg::emit_cmd_t  cmd;

  assign word   = WORD_BITS'(s_axis_tdata_i);
  assign neg    = word[WORD_BITS-1];
  assign mag    = neg ? (~word + 1'b1) : word;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == ST_IDLE) && !emit_busy;

  // Dispatch a request: start BCD, load digits, or load a single character
  always_comb begin
    state_d      = state_q;
    bcd_start    = 1'b0;
    cmd.load     = 1'b0;
    cmd.mode     = s_axis_tuser_i;
    cmd.lit_char = s_axis_tdata_i[7:0];
    cmd.lit_last = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser_i)
            iarf_pkg::REQ_DEC: begin
              bcd_start    = 1'b1;
              state_d      = ST_CONV;
              cmd.load     = neg;
              cmd.mode     = iarf_pkg::REQ_CHAR;
              cmd.lit_char = iarf_pkg::ASCII_MINUS;
              cmd.lit_last = 1'b0;
            end
            iarf_pkg::REQ_HEXL, iarf_pkg::REQ_HEXU, iarf_pkg::REQ_OCT,
            iarf_pkg::REQ_CHAR: begin
              cmd.load = 1'b1;
            end
            iarf_pkg::REQ_PCT: begin
              cmd.load     = 1'b1;
              cmd.mode     = iarf_pkg::REQ_CHAR;
              cmd.lit_char = iarf_pkg::ASCII_PERCENT;
            end
            default: begin
              cmd.load = 1'b0;
            end
          endcase
        end
      end
      ST_CONV: begin
        // Hand the BCD digits over once conversion is done and the sign has left the shifter
        cmd.mode = iarf_pkg::REQ_DEC;
        if (!bcd_busy && !emit_busy) begin
          cmd.load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  iarf_bcd #(
    .WORD_BITS (WORD_BITS)
  ) u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .bin_i   (mag),
    .busy_o  (bcd_busy),
    .bcd_o   (bcd)
  );

  iarf_emit #(
    .WORD_BITS (WORD_BITS)
  ) u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .word_i          (word),
    .bcd_i           (bcd),
    .busy_o          (emit_busy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef NO_ASSERTIONS
  // While converting, no digits are loaded into the emitter until the BCD unit is done
  a_conv_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && bcd_busy) |-> !cmd.load)
    else $error("digits loaded before BCD conversion finished");
`endif

endmodule

>>> hw/rtl/iarf_bcd.sv
// Bit-serial binary to BCD converter (shift and add three), one input bit per cycle.
// Depends on iarf_pkg for the digit count.
module iarf_bcd #(
  parameter int WORD_BITS = iarf_pkg::WORD_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [WORD_BITS-1:0]                        bin_i,
  output logic                                        busy_o,
  output logic [4*iarf_pkg::dec_digits(WORD_BITS)-1:0] bcd_o
);

  localparam int DEC_DIGITS = iarf_pkg::dec_digits(WORD_BITS);
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int CNT_W      = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d, bcd_adj;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  assign busy_o = (cnt_q != '0);
  assign bcd_o  = bcd_q;

  // Add three to every digit of five or more, all digits side by side
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  // Load on start, otherwise shift one bit of the binary word into the digits
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (start_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = CNT_W'(WORD_BITS);
    end else if (busy_o) begin
      bin_d = bin_q << 1;
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[WORD_BITS-1]};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

`ifndef NO_ASSERTIONS
  // A new conversion never cuts into one that is still running
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("bcd converter restarted while busy");
`endif

endmodule

>>> hw/rtl/iarf_emit.sv
// Digit-serial character emitter: shifts digits out MSB first, drops leading zeros,
// maps them to ASCII and holds each character in the output register. Uses iarf_pkg.
module iarf_emit #(
  parameter int WORD_BITS = iarf_pkg::WORD_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  iarf_pkg::emit_cmd_t                         cmd_i,
  input  logic [WORD_BITS-1:0]                        word_i,
  input  logic [4*iarf_pkg::dec_digits(WORD_BITS)-1:0] bcd_i,
  output logic                                        busy_o,
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  output logic [7:0]                                  m_axis_tdata_o,  // [7:0] out_char
  output logic                                        m_axis_tlast_o
);

  localparam int DEC_DIGITS = iarf_pkg::dec_digits(WORD_BITS);
  localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
  localparam int OCT_DIGITS = (WORD_BITS + 2) / 3;
  localparam int W_DEC      = 4 * DEC_DIGITS;
  localparam int W_HEX      = 4 * HEX_DIGITS;
  localparam int W_OCT      = 3 * OCT_DIGITS;
  localparam int W_DH       = (W_DEC > W_HEX) ? W_DEC : W_HEX;
  localparam int SR_W       = (W_DH > W_OCT) ? W_DH : W_OCT;
  localparam int MAX_DIG_DH = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int MAX_DIGITS = (MAX_DIG_DH > OCT_DIGITS) ? MAX_DIG_DH : OCT_DIGITS;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  logic [2:0]       mode_q;
  logic [SR_W-1:0]  sr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             started_q;
  logic [7:0]       lit_q;
  logic             lit_last_q;
  logic             vld_q;
  logic [7:0]       data_q;
  logic             last_q;

  logic       is_lit, is_oct, slot_free, skip, step, emit;
  logic [3:0] dig;
  logic [7:0] char_c;
  logic       last_c;

  assign busy_o    = (cnt_q != '0);
  assign is_lit    = (mode_q == iarf_pkg::REQ_CHAR);
  assign is_oct    = (mode_q == iarf_pkg::REQ_OCT);
  assign dig       = is_oct ? {1'b0, sr_q[SR_W-1 -: 3]} : sr_q[SR_W-1 -: 4];
  assign slot_free = !vld_q || m_axis_tready_i;
  assign skip      = !is_lit && !started_q && (dig == 4'd0) && (cnt_q != CNT_W'(1));
  assign step      = busy_o && (skip || slot_free);
  assign emit      = busy_o && !skip && slot_free;

  // Map the current digit to its character
  always_comb begin
    if (is_lit) begin
      char_c = lit_q;
      last_c = lit_last_q;
    end else begin
      last_c = (cnt_q == CNT_W'(1));
      if (dig <= 4'd9) begin
        char_c = iarf_pkg::ASCII_ZERO + {4'd0, dig};
      end else if (mode_q == iarf_pkg::REQ_HEXL) begin
        char_c = iarf_pkg::ASCII_LOWER_A + {4'd0, dig} - 8'd10;
      end else begin
        char_c = iarf_pkg::ASCII_UPPER_A + {4'd0, dig} - 8'd10;
      end
    end
  end

  // Digit counter and run control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      started_q <= 1'b0;
      mode_q    <= iarf_pkg::REQ_DEC;
    end else if (cmd_i.load) begin
      mode_q    <= cmd_i.mode;
      started_q <= 1'b0;
      case (cmd_i.mode)
        iarf_pkg::REQ_DEC:  cnt_q <= CNT_W'(DEC_DIGITS);
        iarf_pkg::REQ_HEXL: cnt_q <= CNT_W'(HEX_DIGITS);
        iarf_pkg::REQ_HEXU: cnt_q <= CNT_W'(HEX_DIGITS);
        iarf_pkg::REQ_OCT:  cnt_q <= CNT_W'(OCT_DIGITS);
        default:            cnt_q <= CNT_W'(1);
      endcase
    end else if (step) begin
      cnt_q     <= cnt_q - 1'b1;
      started_q <= started_q | emit;
    end
  end

  // Digit shift register, left aligned so the next digit sits at the top
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lit_q      <= cmd_i.lit_char;
      lit_last_q <= cmd_i.lit_last;
      case (cmd_i.mode)
        iarf_pkg::REQ_DEC:  sr_q <= SR_W'(bcd_i) << (SR_W - W_DEC);
        iarf_pkg::REQ_OCT:  sr_q <= SR_W'(word_i) << (SR_W - W_OCT);
        default:            sr_q <= SR_W'(word_i) << (SR_W - W_HEX);
      endcase
    end else if (step) begin
      sr_q <= is_oct ? (sr_q << 3) : (sr_q << 4);
    end
  end

  // Output register: hold the character until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (emit) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      data_q <= char_c;
      last_q <= last_c;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

`ifndef NO_ASSERTIONS
  // Control loads a new run only once the previous one has left the digit shifter
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !busy_o)
    else $error("emitter loaded while a run is in progress");

  // A marked last digit closes the run
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_c && !is_lit && !cmd_i.load) |=> !busy_o)
    else $error("run continues after its last character");

  // Skipped leading zeros never reach the output
  a_skip_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && skip && !vld_q) |=> !vld_q)
    else $error("skipped digit produced a character");
`endif

endmodule
